// ===== rtl/core/path_expected_throughput_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the path expected-throughput block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PATH_EXPECTED_THROUGHPUT_TOP_ASSERT_SVH
`define PATH_EXPECTED_THROUGHPUT_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PET_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pet assertion failed");

// next-cycle implication, disabled in reset
`define PET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pet assertion failed");

// next-cycle implication that also holds across reset
`define PET_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pet assertion failed");

`endif

// ===== rtl/core/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// pet_pkg
// Types, codes and constants shared by the path expected-throughput block.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int MAX_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int WIDTH_W = 5;
  localparam int PROB_W  = 17;
  localparam int TPUT_W  = 21;

  localparam logic [1:0] LINKS_NONE   = 2'd0;
  localparam logic [1:0] LINKS_FIRST  = 2'd1;
  localparam logic [1:0] LINKS_FOLDED = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PWP,   // p power step
    OP_PWQ,   // (1-p) power step
    OP_DPQ,   // p^i * q^(w-i)
    OP_DBN,   // times binomial coefficient
    OP_COPY,  // first link: distribution becomes path distribution
    OP_FA,    // fold, survivor term
    OP_FB,    // fold, new-link term and write back
    OP_SWP,   // swap product step
    OP_EACC,  // expectation accumulate
    OP_RLO,   // result, low part of expectation
    OP_RHI    // result, high part of expectation
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BINOM,
    ST_PWR,
    ST_DIST,
    ST_COPY,
    ST_FOLD,
    ST_SWAP,
    ST_CHKL,
    ST_EXP,
    ST_RES,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic capture;
    logic init_path;
    logic binom_step;
    logic fold_init;
    logic exp_init;
    logic idx_set0;
    logic idx_set1;
    logic idx_setw;
    logic idx_inc;
    logic idx_dec;
    logic out_load;
    logic out_zero;
  } pet_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic idx_eq_w;
    logic idx_is0;
    logic w_is0;
    logic out_busy;
  } pet_sts_t;

endpackage

// ===== rtl/core/pet_ctrl.sv =====
// ----------------------------------------------------------------------------
// pet_ctrl
// Sequencer: binomial build for a first node; powers, distribution, copy or fold and
// swap product for a link node; expectation and result delivery for the last node.
// ----------------------------------------------------------------------------
module pet_ctrl import pet_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pet_sts_t sts,
  output pet_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic       ph_r, ph_nxt;     // 0: issue, 1: write back
  logic       sub_r, sub_nxt;   // which op of a pair
  logic [1:0] links_r, links_nxt;
  logic       zero_r, zero_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= 1'b0;
      sub_r   <= 1'b0;
      links_r <= LINKS_NONE;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      sub_r   <= sub_nxt;
      links_r <= links_nxt;
      zero_r  <= zero_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    sub_nxt   = sub_r;
    links_nxt = links_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ph_nxt  = 1'b0;
        sub_nxt = 1'b0;
        if (sts.first || links_r == LINKS_NONE) begin
          cmd.init_path = 1'b1;
          cmd.idx_set1  = 1'b1;
          links_nxt     = LINKS_FIRST;
          state_nxt     = ST_BINOM;
        end else begin
          cmd.fold_init = 1'b1;
          if (sts.w_is0) begin
            cmd.idx_set0 = 1'b1;
            state_nxt    = ST_DIST;
          end else begin
            cmd.idx_set1 = 1'b1;
            state_nxt    = ST_PWR;
          end
        end
      end
      ST_BINOM: begin
        if (sts.w_is0) begin
          state_nxt = ST_CHKL;
        end else begin
          cmd.binom_step = 1'b1;
          if (sts.idx_eq_w) state_nxt = ST_CHKL;
          else cmd.idx_inc = 1'b1;
        end
      end
      ST_PWR: begin
        if (!ph_r) begin
          cmd.op = sub_r ? OP_PWQ : OP_PWP;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt = 1'b0;
            if (sts.idx_eq_w) begin
              cmd.idx_set0 = 1'b1;
              state_nxt    = ST_DIST;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end
      end
      ST_DIST: begin
        if (!ph_r) begin
          cmd.op = sub_r ? OP_DBN : OP_DPQ;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt = 1'b0;
            if (!sts.idx_eq_w) begin
              cmd.idx_inc = 1'b1;
            end else if (links_r == LINKS_FIRST) begin
              cmd.idx_set0 = 1'b1;
              state_nxt    = ST_COPY;
            end else begin
              cmd.idx_setw = 1'b1;
              state_nxt    = ST_FOLD;
            end
          end
        end
      end
      ST_COPY: begin
        if (!ph_r) begin
          cmd.op = OP_COPY;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (sts.idx_eq_w) begin
            links_nxt = LINKS_FOLDED;
            state_nxt = ST_SWAP;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_FOLD: begin
        if (!ph_r) begin
          cmd.op = sub_r ? OP_FB : OP_FA;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt = 1'b0;
            if (sts.idx_is0) state_nxt = ST_SWAP;
            else cmd.idx_dec = 1'b1;
          end
        end
      end
      ST_SWAP: begin
        if (!ph_r) begin
          cmd.op = OP_SWP;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          state_nxt = ST_CHKL;
        end
      end
      ST_CHKL: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (links_r == LINKS_FOLDED) begin
          cmd.exp_init = 1'b1;
          if (sts.w_is0) begin
            state_nxt = ST_RES;
          end else begin
            cmd.idx_set1 = 1'b1;
            state_nxt    = ST_EXP;
          end
        end else begin
          zero_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EXP: begin
        if (!ph_r) begin
          cmd.op = OP_EACC;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (sts.idx_eq_w) state_nxt = ST_RES;
          else cmd.idx_inc = 1'b1;
        end
      end
      ST_RES: begin
        if (!ph_r) begin
          cmd.op = sub_r ? OP_RHI : OP_RLO;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt   = 1'b0;
            zero_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = zero_r;
          links_nxt    = LINKS_NONE;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/pet_dp.sv =====
// ----------------------------------------------------------------------------
// pet_dp
// Datapath: input latch, distribution stores, binomial lanes, one shared
// multiplier with registered product, accumulators and the output register.
// ----------------------------------------------------------------------------
module pet_dp import pet_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WIDTH_W-1:0]  in_width,
  input  logic [PROB_W-1:0]   in_link_prob,
  input  logic [PROB_W-1:0]   in_swap_prob,
  input  logic                in_first_node,
  input  logic                in_last_node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TPUT_W-1:0]   out_throughput,
  input  pet_cmd_t            cmd,
  output pet_sts_t            sts
);

  localparam int PW    = FRAC_BITS + 1;
  localparam int DEPTH = MAX_WIDTH + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int BW    = MAX_WIDTH;
  localparam int EHW   = $clog2(MAX_WIDTH * (MAX_WIDTH + 1) / 2 + 1);
  localparam int AW0   = (BW > PW) ? BW : PW;
  localparam int AW    = (AW0 > EHW + 1) ? AW0 : EHW + 1;
  localparam int PRW   = AW + PW;
  localparam int EW    = PW + EHW;
  localparam int RW    = PRW + 1;
  localparam int CW    = (PW > PROB_W) ? PW : PROB_W;
  localparam int SW    = (RW > TPUT_W + 1) ? RW : TPUT_W + 1;

  localparam logic [PW-1:0]  ONE     = PW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]  ONE_C   = CW'(1) << FRAC_BITS;
  localparam logic [PRW-1:0] ONE_P   = PRW'(1) << FRAC_BITS;
  localparam logic [PW:0]    ONE_S   = (PW + 1)'(1) << FRAC_BITS;
  localparam logic [SW-1:0]  OUT_MAX = SW'((64'd1 << TPUT_W) - 64'd1);

  // input latch
  logic [WIDTH_W-1:0] win_r;
  logic [PW-1:0]      p_r, sw_r;
  logic               first_r, last_r;
  logic [CW-1:0]      lp_ext, sp_ext;

  // path state
  logic [WW-1:0] w_r, idx_r, wsat;
  logic [PW-1:0] path_r  [DEPTH];
  logic [PW-1:0] dist_r  [DEPTH];
  logic [PW-1:0] pwp_r   [DEPTH];
  logic [PW-1:0] pwq_r   [DEPTH];
  logic [BW-1:0] binom_r [DEPTH];
  logic [PW-1:0] swap_r, tmp_r, acc_r, sq_r, sp_r;
  logic [EW-1:0] e_r;
  logic [RW-1:0] res_r;

  // multiplier
  logic [AW-1:0]  mul_a;
  logic [PW-1:0]  mul_b;
  logic [PRW-1:0] prod_r;
  op_t            op_r;
  logic [WW-1:0]  idx_op_r;

  logic [PW-1:0]  q;
  logic [PW:0]    sq_sum, fb_sum, sp_sum;
  logic [PW-1:0]  sq_n, fb_val, sp_val, prod_sh;
  logic [WW-1:0]  idx_m1, idx_wm;

  logic [TPUT_W-1:0] tput_r;
  logic              out_valid_r;

  assign lp_ext = CW'(in_link_prob);
  assign sp_ext = CW'(in_swap_prob);
  assign wsat   = ({1'b0, win_r} > 6'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(win_r);

  assign q       = ONE - p_r;
  assign idx_m1  = idx_r - WW'(1);
  assign idx_wm  = w_r - idx_r;
  assign sq_sum  = {1'b0, sq_r} + {1'b0, dist_r[idx_r]};
  assign sq_n    = (sq_sum > ONE_S) ? ONE : sq_sum[PW-1:0];
  assign prod_sh = prod_r[FRAC_BITS +: PW];
  assign fb_sum  = {1'b0, acc_r} + {1'b0, prod_sh};
  assign fb_val  = (fb_sum > ONE_S) ? ONE : fb_sum[PW-1:0];
  assign sp_sum  = {1'b0, sp_r} + {1'b0, path_r[idx_op_r]};
  assign sp_val  = (sp_sum > ONE_S) ? ONE : sp_sum[PW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PWP:  begin mul_a = AW'(pwp_r[idx_m1]); mul_b = p_r; end
      OP_PWQ:  begin mul_a = AW'(pwq_r[idx_m1]); mul_b = q; end
      OP_DPQ:  begin mul_a = AW'(pwp_r[idx_r]); mul_b = pwq_r[idx_wm]; end
      OP_DBN:  begin mul_a = AW'(binom_r[idx_r]); mul_b = tmp_r; end
      OP_FA:   begin mul_a = AW'(path_r[idx_r]); mul_b = sq_n; end
      OP_FB:   begin mul_a = AW'(dist_r[idx_r]); mul_b = sp_r; end
      OP_SWP:  begin mul_a = AW'(swap_r); mul_b = sw_r; end
      OP_EACC: begin mul_a = AW'(idx_r); mul_b = path_r[idx_r]; end
      OP_RLO:  begin mul_a = AW'(e_r[FRAC_BITS-1:0]); mul_b = swap_r; end
      OP_RHI:  begin mul_a = AW'(e_r[EW-1:FRAC_BITS]); mul_b = swap_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
      w_r         <= '0;
      idx_r       <= '0;
    end else begin
      op_r <= cmd.op;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.init_path) w_r <= wsat;
      if (cmd.idx_set0) idx_r <= '0;
      else if (cmd.idx_set1) idx_r <= WW'(1);
      else if (cmd.idx_setw) idx_r <= w_r;
      else if (cmd.idx_inc) idx_r <= idx_r + WW'(1);
      else if (cmd.idx_dec) idx_r <= idx_m1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r   <= PRW'(mul_a) * PRW'(mul_b);
    idx_op_r <= idx_r;
    if (cmd.capture) begin
      win_r   <= in_width;
      p_r     <= PW'((lp_ext > ONE_C) ? ONE_C : lp_ext);
      sw_r    <= PW'((sp_ext > ONE_C) ? ONE_C : sp_ext);
      first_r <= in_first_node;
      last_r  <= in_last_node;
    end
    if (cmd.init_path) begin
      swap_r <= sw_r;
      for (int i = 0; i < DEPTH; i++) begin
        path_r[i]  <= '0;
        binom_r[i] <= (i == 0) ? BW'(1) : '0;
      end
    end
    if (cmd.binom_step) begin
      for (int i = 1; i < DEPTH; i++) binom_r[i] <= binom_r[i] + binom_r[i-1];
    end
    if (cmd.fold_init) begin
      sq_r     <= '0;
      sp_r     <= '0;
      pwp_r[0] <= ONE;
      pwq_r[0] <= ONE;
    end
    if (cmd.exp_init) e_r <= '0;
    if (cmd.op == OP_FA) sq_r <= sq_n;
    if (cmd.out_load) begin
      if (cmd.out_zero) tput_r <= '0;
      else if (SW'(res_r) > OUT_MAX) tput_r <= '1;
      else tput_r <= TPUT_W'(res_r);
    end
    // write back of the previous issue
    case (op_r)
      OP_PWP:  pwp_r[idx_op_r] <= prod_sh;
      OP_PWQ:  pwq_r[idx_op_r] <= prod_sh;
      OP_DPQ:  tmp_r <= prod_sh;
      OP_DBN:  dist_r[idx_op_r] <= (prod_r > ONE_P) ? ONE : prod_r[PW-1:0];
      OP_COPY: path_r[idx_op_r] <= dist_r[idx_op_r];
      OP_FA:   acc_r <= prod_sh;
      OP_FB: begin
        path_r[idx_op_r] <= fb_val;
        sp_r             <= sp_val;
      end
      OP_SWP:  swap_r <= prod_sh;
      OP_EACC: e_r <= e_r + prod_r[EW-1:0];
      OP_RLO:  res_r <= RW'(prod_r >> FRAC_BITS);
      OP_RHI:  res_r <= res_r + RW'(prod_r);
      default: ;
    endcase
  end

  assign sts.first    = first_r;
  assign sts.last     = last_r;
  assign sts.idx_eq_w = (idx_r == w_r);
  assign sts.idx_is0  = (idx_r == '0);
  assign sts.w_is0    = (w_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_throughput = tput_r;

endmodule

// ===== rtl/core/path_expected_throughput_top.sv =====
// Sequence, accept to in_ready: a first node builds the binomial row; a link node runs
//   powers, distribution, copy (first link) or fold, and swap; the last node adds the
//   expectation and result steps (none with no links), out_valid with in_ready.
// One node at a time, paced by the single shared multiplier (issue, then write back).
// Reset: synchronous active-low rst_n clears the sequencer, path status and output
//   valid; the distribution stores are rewritten before each use.
// ----------------------------------------------------------------------------
// path_expected_throughput_top
// Expected throughput of a path: binomial link distributions folded into the
// distribution of the path's minimum channel count, times the swap product.
// ----------------------------------------------------------------------------
module path_expected_throughput_top import pet_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,  // 1..32
  parameter int FRAC_BITS = FRAC_BITS_DEF   // 8..30
) (
  input  logic               clk,
  input  logic               rst_n,
  // node transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WIDTH_W-1:0] in_width,
  input  logic [PROB_W-1:0]  in_link_prob,
  input  logic [PROB_W-1:0]  in_swap_prob,
  input  logic               in_first_node,
  input  logic               in_last_node,
  // result transaction
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TPUT_W-1:0]  out_throughput
);

  // The controller steps through each node; the datapath holds every store
  // and the one multiplier. They talk only through cmd and sts.
  pet_cmd_t cmd;
  pet_sts_t sts;

  pet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Result sits in an output register, so a new node is taken while it waits;
  // only a second result stalls until the first transaction completes.
  pet_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_width       (in_width),
    .in_link_prob   (in_link_prob),
    .in_swap_prob   (in_swap_prob),
    .in_first_node  (in_first_node),
    .in_last_node   (in_last_node),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_throughput (out_throughput),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== rtl/core/pet_checker.sv =====
// ----------------------------------------------------------------------------
// pet_checker
// Port-level checks of the path expected-throughput block, bound to the top.
// ----------------------------------------------------------------------------
`include "path_expected_throughput_top_assert.svh"

module pet_checker import pet_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TPUT_W-1:0] out_throughput
);

  // stalled result holds
  `PET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_throughput))
  // no result right out of reset
  `PET_ASSERT_RST(a_rst_quiet, !rst_n, !out_valid)
  // one node at a time: busy after taking a transaction
  `PET_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // a result only appears from the busy sequencer
  `PET_ASSERT_SAME(a_out_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind path_expected_throughput_top pet_checker u_pet_chk (.*);

// ===== sim/pet_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_scoreboard
// Watches the node and result channels of the path expected-throughput block,
// predicts each path's throughput and compares every result transaction.
// ----------------------------------------------------------------------------
module pet_scoreboard import pet_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [WIDTH_W-1:0] in_width,
  input  logic [PROB_W-1:0]  in_link_prob,
  input  logic [PROB_W-1:0]  in_swap_prob,
  input  logic               in_first_node,
  input  logic               in_last_node,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [TPUT_W-1:0]  out_throughput,
  output int                 fail_count,
  output int                 pending
);

  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned UNITY = 64'd1 << FB;
  localparam longint unsigned TPUT_MAX = (64'd1 << TPUT_W) - 1;

  longint unsigned min_dist [0:MAXW];
  longint unsigned coef [0:MAXW];
  longint unsigned swap_acc;
  int unsigned     chan_w;
  logic [1:0]      path_state;
  logic [TPUT_W-1:0] tput_queue [$];

  function automatic longint unsigned sat1(longint unsigned v);
    return v > UNITY ? UNITY : v;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> FB;
  endfunction

  task automatic fold_link(longint unsigned p);
    longint unsigned pp [0:MAXW];
    longint unsigned pq [0:MAXW];
    longint unsigned link_dist [0:MAXW];
    longint unsigned next_dist [0:MAXW];
    longint unsigned q, tail_q, tail_p;
    q = UNITY - p;
    pp[0] = UNITY;
    pq[0] = UNITY;
    for (int i = 1; i <= chan_w; i++) begin
      pp[i] = qmul(pp[i-1], p);
      pq[i] = qmul(pq[i-1], q);
    end
    for (int i = 0; i <= chan_w; i++)
      link_dist[i] = sat1(coef[i] * qmul(pp[i], pq[chan_w-i]));
    if (path_state != LINKS_FOLDED) begin
      for (int i = 0; i <= chan_w; i++) min_dist[i] = link_dist[i];
      path_state = LINKS_FOLDED;
    end else begin
      tail_q = 0;
      tail_p = 0;
      for (int k = chan_w; k >= 0; k--) begin
        tail_q = sat1(tail_q + link_dist[k]);
        next_dist[k] = sat1(qmul(min_dist[k], tail_q) + qmul(link_dist[k], tail_p));
        tail_p = sat1(tail_p + min_dist[k]);
      end
      for (int i = 0; i <= chan_w; i++) min_dist[i] = next_dist[i];
    end
  endtask

  task automatic predict_node();
    longint unsigned lp, sp, e, r;
    lp = sat1(in_link_prob);
    sp = sat1(in_swap_prob);
    if (in_first_node || path_state == LINKS_NONE) begin
      chan_w = in_width > MAXW ? MAXW : in_width;
      for (int i = 0; i <= MAXW; i++) begin
        coef[i] = 0;
        min_dist[i] = 0;
      end
      coef[0] = 1;
      for (int n = 1; n <= chan_w; n++)
        for (int i = n; i >= 1; i--) coef[i] += coef[i-1];
      swap_acc = sp;
      path_state = LINKS_FIRST;
    end else begin
      fold_link(lp);
      swap_acc = qmul(swap_acc, sp);
    end
    if (in_last_node) begin
      r = 0;
      if (path_state == LINKS_FOLDED) begin
        e = 0;
        for (int i = 1; i <= chan_w; i++) e += i * min_dist[i];
        r = qmul(e, swap_acc);
        if (r > TPUT_MAX) r = TPUT_MAX;
      end
      tput_queue.insert(tput_queue.size(), r[TPUT_W-1:0]);
      path_state = LINKS_NONE;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  assign pending = tput_queue.size();

  initial begin
    fail_count = 0;
    path_state = LINKS_NONE;
    chan_w = 0;
    swap_acc = UNITY;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_node();
      if (out_valid && out_ready) begin
        if (tput_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected throughput %0d", out_throughput));
        end else begin
          if (out_throughput !== tput_queue[0])
            report_mismatch($sformatf("throughput %0d, predicted %0d",
                                      out_throughput, tput_queue[0]));
          void'(tput_queue.pop_front());
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Node stream stimulus for the path expected-throughput block: directed
// corner paths, then random paths, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import pet_pkg::*;

  localparam int NODE_COUNT = 1650;
  localparam int STALL_LIMIT = 20000;  // worst-case node time, many times over

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [WIDTH_W-1:0] in_width = '0;
  logic [PROB_W-1:0]  in_link_prob = '0;
  logic [PROB_W-1:0]  in_swap_prob = '0;
  logic               in_first_node = 1'b0;
  logic               in_last_node = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TPUT_W-1:0]  out_throughput;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 calm = 1'b0;      // no idling on either side
  bit                 hold_off = 1'b0;  // receiver long stall
  bit                 stim_done = 1'b0;

  always #6 clk = ~clk;

  path_expected_throughput_top dut (.*);

  pet_scoreboard chk (.*);

  // Random probability, biased toward the corners and over-one values.
  function automatic logic [PROB_W-1:0] rand_prob();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'(65536 + $urandom_range(65535));
      3: return 17'(65536 - $urandom_range(64));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  // One node transaction; idles at random first, returns at acceptance.
  // Valid stays high on return so back-to-back nodes need no extra edge.
  task automatic send_node(int w, logic [PROB_W-1:0] lp, logic [PROB_W-1:0] sp,
                           bit first, bit last);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_width <= WIDTH_W'(w);
    in_link_prob <= lp;
    in_swap_prob <= sp;
    in_first_node <= first;
    in_last_node <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Well-formed path of hops links with random content.
  task automatic send_path(int w, int hops);
    send_node(w, rand_prob(), rand_prob(), 1'b1, hops == 0);
    for (int h = 1; h <= hops; h++)
      send_node($urandom_range(31), rand_prob(), rand_prob(), 1'b0, h == hops);
  endtask

  // Receiver: random ready, off during the hold-off stretch.
  always @(posedge clk) begin
    out_ready <= !hold_off && (calm || $urandom_range(99) >= 13);
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("path_expected_throughput_top verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner paths and special cases
    send_node(16, 17'd0, 17'd65536, 1'b1, 1'b1);         // path without links
    send_node(16, 17'd0, 17'd65536, 1'b1, 1'b0);         // full width, certain links
    send_node(0, 17'd65536, 17'd65536, 1'b0, 1'b0);
    send_node(0, 17'h1ffff, 17'h1ffff, 1'b0, 1'b1);      // over one clamps
    send_node(0, 17'd0, 17'd0, 1'b1, 1'b0);              // width zero
    send_node(0, 17'd30000, 17'd65536, 1'b0, 1'b1);
    send_node(31, 17'd0, 17'd40000, 1'b0, 1'b0);         // no path open, width saturates
    send_node(5, 17'd0, 17'd65535, 1'b0, 1'b0);          // link probability zero
    send_node(3, 17'd32768, 17'd50000, 1'b1, 1'b0);      // restart mid-path
    send_node(3, 17'd65535, 17'd65535, 1'b0, 1'b0);
    send_node(3, 17'd32768, 17'd0, 1'b0, 1'b0);          // swap zero
    send_node(3, 17'd20000, 17'd65536, 1'b0, 1'b1);
    send_node(1, 17'd65536, 17'd65536, 1'b1, 1'b0);      // width one
    send_node(1, 17'd10000, 17'd65536, 1'b0, 1'b1);
    send_node(16, 17'h1ffff, 17'd65536, 1'b1, 1'b0);
    send_node(16, 17'd65536, 17'd65536, 1'b0, 1'b0);
    send_node(16, 17'h15555, 17'h0aaaa, 1'b0, 1'b1);
    sent = 17;

    // receiver holds off while the sender keeps offering nodes
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 10; i++) send_node(2, 17'd40000, 17'd60000, 1'b1, 1'b1);
    sent += 10;

    // random: mostly well-formed paths, small widths dominate; some noise
    while (sent < NODE_COUNT) begin
      int hops, w;
      calm = (sent > 700 && sent < 850);
      hops = $urandom_range(4);
      w = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(6);
      if ($urandom_range(9) == 0) begin
        send_node($urandom_range(31), 17'($urandom), 17'($urandom),
                  1'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_path(w, hops);
        sent += hops + 1;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;
  end

  // Verdict once every predicted result has arrived.
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("path_expected_throughput_top verification clean");
    end else begin
      $display("path_expected_throughput_top verification failed");
    end
    $finish;
  end

endmodule

// ===== path_expected_throughput_top.f =====
+incdir+rtl/core
rtl/core/pet_pkg.sv
rtl/core/pet_ctrl.sv
rtl/core/pet_dp.sv
rtl/core/path_expected_throughput_top.sv
rtl/core/pet_checker.sv
sim/pet_checker.sv
sim/tb.sv
